/* sv/tckvs_pkg.sv */
// Shared types, constants and the velocity curve of the two-contact key velocity scanner.
package tckvs_pkg;

   // Number of keys and the width of a key index.
   localparam int KEYS = 16;
   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(KEYS - 1);

   // Counter and message field widths.
   localparam int CNT_W = 7;
   localparam int CONTACT_W = 32;
   localparam logic [CNT_W-1:0] CNT_RELOAD = 7'h7f;

   // Register reset values.
   localparam logic [7:0] STATUS_RESET = 8'h90;
   localparam logic [6:0] BASE_NOTE_RESET = 7'h24;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_STATUS = 1'b0,
      CSR_BASE_NOTE = 1'b1
   } csr_index_type;

   // Input commands.
   typedef enum logic [0:0] {
      CMD_TICK = 1'b0,
      CMD_TOGGLE = 1'b1
   } command_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   // Position of a byte within a note message.
   typedef enum logic [1:0] {
      BYTE_STATUS = 2'd0,
      BYTE_NOTE = 2'd1,
      BYTE_VELOCITY = 2'd2
   } byte_sel_type;

   // One key update step handed from the sequencer to the key store.
   typedef struct packed {
      logic scan_en;
      logic [KEY_W-1:0] idx;
      logic first_bit;
      logic second_bit;
   } key_cmd_type;

   // Velocity curve, indexed by the captured count.
   localparam logic [6:0] VEL_CURVE [128] = '{
      7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01,
      7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01,
      7'h01, 7'h01, 7'h01, 7'h02, 7'h02, 7'h02, 7'h02, 7'h02,
      7'h02, 7'h02, 7'h02, 7'h02, 7'h02, 7'h03, 7'h03, 7'h03,
      7'h03, 7'h03, 7'h03, 7'h03, 7'h03, 7'h04, 7'h04, 7'h04,
      7'h04, 7'h04, 7'h04, 7'h05, 7'h05, 7'h05, 7'h05, 7'h06,
      7'h06, 7'h06, 7'h06, 7'h07, 7'h07, 7'h07, 7'h07, 7'h08,
      7'h08, 7'h08, 7'h09, 7'h09, 7'h09, 7'h0a, 7'h0a, 7'h0b,
      7'h0b, 7'h0b, 7'h0c, 7'h0c, 7'h0d, 7'h0d, 7'h0e, 7'h0f,
      7'h0f, 7'h10, 7'h10, 7'h11, 7'h12, 7'h12, 7'h13, 7'h14,
      7'h15, 7'h16, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1a, 7'h1b,
      7'h1c, 7'h1d, 7'h1f, 7'h20, 7'h21, 7'h22, 7'h24, 7'h25,
      7'h27, 7'h28, 7'h2a, 7'h2b, 7'h2d, 7'h2f, 7'h31, 7'h33,
      7'h35, 7'h37, 7'h39, 7'h3b, 7'h3d, 7'h40, 7'h42, 7'h45,
      7'h48, 7'h4a, 7'h4d, 7'h50, 7'h54, 7'h57, 7'h5a, 7'h5e,
      7'h61, 7'h65, 7'h69, 7'h6d, 7'h72, 7'h76, 7'h7b, 7'h7f
   };

endpackage

/* sv/two_contact_key_velocity_scanner.sv */
// Top level of the two-contact key velocity scanner.
// A scan tick is accepted and then the sequencer walks the keys in turn through the
// single counter update unit; a toggle of a second contact is accepted, its velocity is
// looked up and its three-byte note message is sent byte by byte, each byte waiting while
// rsp_stall holds the output register. The block
// stalls its input while it works on an item, and a finished byte waits in the output
// register while the next item is accepted. Even pins give no message. The status byte
// and base note registers may be written at any time the block is idle.
module two_contact_key_velocity_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_contacts,
   input  logic [4:0]  req_pin,
   input  logic        req_pin_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_midi_byte,
   output logic        rsp_message_end,
   output logic [3:0]  rsp_last_key,
   output logic [6:0]  rsp_press_velocity,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import tckvs_pkg::*;

   logic [7:0]        status_ff;
   logic [6:0]        base_note_ff;
   key_cmd_type       key_cmd;
   logic [KEY_W-1:0]  rd_idx;
   logic [CNT_W-1:0]  rd_captured;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= STATUS_RESET;
         base_note_ff <= BASE_NOTE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STATUS: status_ff <= csr_data;
            CSR_BASE_NOTE: base_note_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   tckvs_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_contacts       (req_contacts),
      .req_pin            (req_pin),
      .req_pin_level      (req_pin_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_midi_byte      (rsp_midi_byte),
      .rsp_message_end    (rsp_message_end),
      .rsp_last_key       (rsp_last_key),
      .rsp_press_velocity (rsp_press_velocity),
      .status_byte        (status_ff),
      .base_note          (base_note_ff),
      .key_cmd            (key_cmd),
      .rd_idx             (rd_idx),
      .rd_captured        (rd_captured)
   );

   tckvs_key_store u_key_store (
      .clock       (clock),
      .reset       (reset),
      .key_cmd     (key_cmd),
      .rd_idx      (rd_idx),
      .rd_captured (rd_captured)
   );

endmodule

/* sv/tckvs_key_store.sv */
// Per-key counter and capture store with the shared counter update unit.
module tckvs_key_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tckvs_pkg::key_cmd_type               key_cmd,
   input  logic [tckvs_pkg::KEY_W-1:0]          rd_idx,
   output logic [tckvs_pkg::CNT_W-1:0]          rd_captured
);
   import tckvs_pkg::*;

   logic [CNT_W-1:0] counter_ff [KEYS];
   logic [CNT_W-1:0] captured_ff [KEYS];
   logic [CNT_W-1:0] cur_count;
   logic [CNT_W-1:0] counter_in;
   logic             capture_en;

   // The one update unit: reload, saturating decrement or capture.
   always_comb begin
      cur_count = counter_ff[key_cmd.idx];
      counter_in = cur_count;
      capture_en = 1'b0;
      if (!key_cmd.first_bit) begin
         counter_in = CNT_RELOAD;
      end else if (key_cmd.second_bit) begin
         if (cur_count != '0) begin
            counter_in = cur_count - 1'b1;
         end
      end else begin
         capture_en = 1'b1;
      end
   end

   // Store write for the key at the sequencer's index.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYS; k++) begin
            counter_ff[k] <= CNT_RELOAD;
            captured_ff[k] <= '0;
         end
      end else if (key_cmd.scan_en) begin
         counter_ff[key_cmd.idx] <= counter_in;
         if (capture_en) begin
            captured_ff[key_cmd.idx] <= cur_count;
         end
      end
   end

   // Capture read for the velocity lookup.
   assign rd_captured = captured_ff[rd_idx];

   a_reload: assert property (@(posedge clock) disable iff (reset)
      key_cmd.scan_en && !key_cmd.first_bit |=> counter_ff[$past(key_cmd.idx)] == CNT_RELOAD)
      else $error("counter not reloaded while first contact open");
   a_capture: assert property (@(posedge clock) disable iff (reset)
      key_cmd.scan_en && key_cmd.first_bit && !key_cmd.second_bit
      |=> captured_ff[$past(key_cmd.idx)] == counter_ff[$past(key_cmd.idx)])
      else $error("captured count does not match held counter");
   a_decrement: assert property (@(posedge clock) disable iff (reset)
      key_cmd.scan_en && key_cmd.first_bit && key_cmd.second_bit && cur_count != '0
      |=> counter_ff[$past(key_cmd.idx)] == $past(cur_count) - 1'b1)
      else $error("counter did not count down");

endmodule

/* sv/tckvs_ctrl.sv */
// Sequencer: walks the keys on a scan tick and sends note messages on a toggle.
module tckvs_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [31:0]                          req_contacts,
   input  logic [4:0]                           req_pin,
   input  logic                                 req_pin_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_midi_byte,
   output logic                                 rsp_message_end,
   output logic [3:0]                           rsp_last_key,
   output logic [6:0]                           rsp_press_velocity,
   input  logic [7:0]                           status_byte,
   input  logic [6:0]                           base_note,
   output tckvs_pkg::key_cmd_type               key_cmd,
   output logic [tckvs_pkg::KEY_W-1:0]          rd_idx,
   input  logic [tckvs_pkg::CNT_W-1:0]          rd_captured
);
   import tckvs_pkg::*;

   state_type          state_ff, state_in;
   logic [KEY_W-1:0]   idx_ff;
   logic [CONTACT_W-1:0] contacts_ff;
   logic [KEY_W-1:0]   key_ff;
   logic               level_ff;
   byte_sel_type       byte_sel_ff;
   logic [6:0]         vel_ff;
   logic [3:0]         recent_key_ff;
   logic [6:0]         recent_vel_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_end_ff;
   logic [3:0]         rsp_key_ff;
   logic [6:0]         rsp_vel_ff;

   logic               accept;
   logic               start_scan;
   logic               start_toggle;
   logic               scan_last;
   logic               out_free;
   logic               emit_load;
   logic [7:0]         emit_byte;

   // Decode of an accepted beat.
   assign accept = req_valid && !req_stall;
   assign start_scan = accept && (req_command == CMD_TICK);
   assign start_toggle = accept && (req_command == CMD_TOGGLE) && req_pin[0]
      && (32'(req_pin[4:1]) < 32'(KEYS));
   assign scan_last = (idx_ff == LAST_KEY);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_scan) begin
               state_in = ST_SCAN;
            end else if (start_toggle) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free && byte_sel_ff == BYTE_VELOCITY) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer. The current key's two contact bits sit at the
   // bottom of the shift register.
   always_comb begin
      req_stall = 1'b1;
      key_cmd.scan_en = 1'b0;
      key_cmd.idx = idx_ff;
      key_cmd.first_bit = contacts_ff[0];
      key_cmd.second_bit = contacts_ff[1];
      emit_load = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SCAN: key_cmd.scan_en = 1'b1;
         ST_LOOKUP: ;
         ST_EMIT: emit_load = out_free;
         default: ;
      endcase
   end

   assign rd_idx = key_ff;

   // Byte of the message at the current position.
   always_comb begin
      case (byte_sel_ff)
         BYTE_STATUS: emit_byte = status_byte;
         BYTE_NOTE: emit_byte = {1'b0, base_note + 7'(key_ff)};
         BYTE_VELOCITY: emit_byte = {1'b0, vel_ff};
         default: emit_byte = '0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         recent_key_ff <= '0;
         recent_vel_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (out_free) begin
            rsp_valid_ff <= emit_load;
         end
         if (state_ff == ST_LOOKUP && !level_ff) begin
            recent_key_ff <= 4'(key_ff);
            recent_vel_ff <= VEL_CURVE[rd_captured];
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      if (start_scan) begin
         idx_ff <= '0;
         contacts_ff <= req_contacts;
      end else if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + 1'b1;
         contacts_ff <= {2'b00, contacts_ff[CONTACT_W-1:2]};
      end
      if (start_toggle) begin
         key_ff <= KEY_W'(req_pin[4:1]);
         level_ff <= req_pin_level;
      end
      if (state_ff == ST_LOOKUP) begin
         vel_ff <= level_ff ? 7'd0 : VEL_CURVE[rd_captured];
         byte_sel_ff <= BYTE_STATUS;
      end else if (emit_load) begin
         byte_sel_ff <= byte_sel_type'(byte_sel_ff + 2'd1);
      end
      if (emit_load) begin
         rsp_byte_ff <= emit_byte;
         rsp_end_ff <= (byte_sel_ff == BYTE_VELOCITY);
         rsp_key_ff <= recent_key_ff;
         rsp_vel_ff <= recent_vel_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_midi_byte = rsp_byte_ff;
   assign rsp_message_end = rsp_end_ff;
   assign rsp_last_key = rsp_key_ff;
   assign rsp_press_velocity = rsp_vel_ff;

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && scan_last |=> state_ff == ST_IDLE)
      else $error("scan did not end after the last key");
   a_lookup_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> state_ff == ST_EMIT && byte_sel_ff == BYTE_STATUS)
      else $error("message did not start with the status byte");
   a_end_byte_small: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> !rsp_byte_ff[7])
      else $error("velocity byte has its top bit set");

endmodule

/* verif/tckvs_checker.sv */
// Checker for the key velocity scanner: follows every beat, predicts note messages and compares them.
module tckvs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_contacts,
   input  logic [4:0]  req_pin,
   input  logic        req_pin_level,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_midi_byte,
   input  logic        rsp_message_end,
   input  logic [3:0]  rsp_last_key,
   input  logic [6:0]  rsp_press_velocity,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          beats_pending
);
   import tckvs_pkg::*;

   localparam int NUM_KEYS = 16;
   localparam logic [6:0] FULL_COUNT = 7'd127;

   // One byte of a note message as it should leave the block.
   typedef struct packed {
      logic [7:0] midi_byte;
      logic       message_end;
      logic [3:0] last_key;
      logic [6:0] press_velocity;
   } note_beat_type;

   // Velocity curve, indexed by the captured count.
   localparam logic [6:0] VELOCITY_MAP [128] = '{
      7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01,
      7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01, 7'h01,
      7'h01, 7'h01, 7'h01, 7'h02, 7'h02, 7'h02, 7'h02, 7'h02,
      7'h02, 7'h02, 7'h02, 7'h02, 7'h02, 7'h03, 7'h03, 7'h03,
      7'h03, 7'h03, 7'h03, 7'h03, 7'h03, 7'h04, 7'h04, 7'h04,
      7'h04, 7'h04, 7'h04, 7'h05, 7'h05, 7'h05, 7'h05, 7'h06,
      7'h06, 7'h06, 7'h06, 7'h07, 7'h07, 7'h07, 7'h07, 7'h08,
      7'h08, 7'h08, 7'h09, 7'h09, 7'h09, 7'h0a, 7'h0a, 7'h0b,
      7'h0b, 7'h0b, 7'h0c, 7'h0c, 7'h0d, 7'h0d, 7'h0e, 7'h0f,
      7'h0f, 7'h10, 7'h10, 7'h11, 7'h12, 7'h12, 7'h13, 7'h14,
      7'h15, 7'h16, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1a, 7'h1b,
      7'h1c, 7'h1d, 7'h1f, 7'h20, 7'h21, 7'h22, 7'h24, 7'h25,
      7'h27, 7'h28, 7'h2a, 7'h2b, 7'h2d, 7'h2f, 7'h31, 7'h33,
      7'h35, 7'h37, 7'h39, 7'h3b, 7'h3d, 7'h40, 7'h42, 7'h45,
      7'h48, 7'h4a, 7'h4d, 7'h50, 7'h54, 7'h57, 7'h5a, 7'h5e,
      7'h61, 7'h65, 7'h69, 7'h6d, 7'h72, 7'h76, 7'h7b, 7'h7f
   };

   // Predicted state of the keys and the registers.
   logic [6:0] fall_count [NUM_KEYS];
   logic [6:0] held_count [NUM_KEYS];
   logic [3:0] recent_key;
   logic [6:0] recent_velocity;
   logic [7:0] status_reg;
   logic [6:0] base_note_reg;
   note_beat_type note_fifo [$];

   task automatic report(input string msg);
      $display("checker: %s", msg);
      mismatch_count += 1;
   endtask

   // A scan tick reloads, counts down or captures each key's counter.
   task automatic apply_scan(input logic [31:0] contacts);
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (!contacts[2*k]) begin
            fall_count[k] = FULL_COUNT;
         end else if (contacts[2*k+1]) begin
            if (fall_count[k] != 7'd0) fall_count[k] = fall_count[k] - 7'd1;
         end else begin
            held_count[k] = fall_count[k];
         end
      end
   endtask

   // A second-contact toggle gives status, note and velocity beats.
   task automatic queue_note(input logic [4:0] pin, input logic level);
      logic [3:0] key;
      logic [6:0] velocity;
      logic [6:0] note;
      note_beat_type beat;
      if (pin[0]) begin
         key = pin[4:1];
         if (!level) begin
            recent_key = key;
            recent_velocity = VELOCITY_MAP[held_count[key]];
            velocity = recent_velocity;
         end else begin
            velocity = 7'd0;
         end
         note = base_note_reg + 7'(key);
         beat.last_key = recent_key;
         beat.press_velocity = recent_velocity;
         beat.message_end = 1'b0;
         beat.midi_byte = status_reg;
         note_fifo.push_back(beat);
         beat.midi_byte = {1'b0, note};
         note_fifo.push_back(beat);
         beat.message_end = 1'b1;
         beat.midi_byte = {1'b0, velocity};
         note_fifo.push_back(beat);
      end
   endtask

   // Follow register writes, accepted items and delivered beats.
   always @(posedge clock) begin : watch
      note_beat_type want;
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            fall_count[k] = FULL_COUNT;
            held_count[k] = 7'd0;
         end
         recent_key = 4'd0;
         recent_velocity = 7'd0;
         status_reg = 8'h90;
         base_note_reg = 7'h24;
         mismatch_count = 0;
         note_fifo.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_STATUS: status_reg = csr_data;
               CSR_BASE_NOTE: base_note_reg = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (command_type'(req_command) == CMD_TICK) apply_scan(req_contacts);
            else queue_note(req_pin, req_pin_level);
         end
         if (rsp_valid && !rsp_stall) begin
            if (note_fifo.size() == 0) begin
               report($sformatf("beat 0x%0h arrived with nothing expected", rsp_midi_byte));
            end else begin
               want = note_fifo.pop_front();
               if (rsp_midi_byte !== want.midi_byte)
                  report($sformatf("midi_byte 0x%0h, expected 0x%0h",
                                   rsp_midi_byte, want.midi_byte));
               if (rsp_message_end !== want.message_end)
                  report($sformatf("message_end %0b, expected %0b",
                                   rsp_message_end, want.message_end));
               if (rsp_last_key !== want.last_key)
                  report($sformatf("last_key %0d, expected %0d",
                                   rsp_last_key, want.last_key));
               if (rsp_press_velocity !== want.press_velocity)
                  report($sformatf("press_velocity 0x%0h, expected 0x%0h",
                                   rsp_press_velocity, want.press_velocity));
            end
         end
      end
      beats_pending <= note_fifo.size();
   end

endmodule

/* verif/testbench.sv */
// Top of the scanner testbench: clock, reset, stimulus, back pressure, watchdog and verdict.
module testbench;
   import tckvs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [31:0] req_contacts;
   logic [4:0]  req_pin;
   logic        req_pin_level;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_midi_byte;
   logic        rsp_message_end;
   logic [3:0]  rsp_last_key;
   logic [6:0]  rsp_press_velocity;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   int mismatch_count;
   int beats_pending;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_asks;
   int items_offered;
   int quiet_cycles;

   two_contact_key_velocity_scanner DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_contacts(req_contacts), .req_pin(req_pin), .req_pin_level(req_pin_level),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_midi_byte(rsp_midi_byte),
      .rsp_message_end(rsp_message_end), .rsp_last_key(rsp_last_key),
      .rsp_press_velocity(rsp_press_velocity),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   tckvs_checker note_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_contacts(req_contacts), .req_pin(req_pin), .req_pin_level(req_pin_level),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_midi_byte(rsp_midi_byte),
      .rsp_message_end(rsp_message_end), .rsp_last_key(rsp_last_key),
      .rsp_press_velocity(rsp_press_velocity),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count), .beats_pending(beats_pending)
   );

   // Free-running clock, period 8.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Result side: random stalls, plus a long hold-off whenever one is asked for.
   initial begin : receiver
      int hold_taken;
      int hold_left;
      hold_taken = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: end the run if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Offer one item after a random gap and hold it until the block takes it.
   task automatic offer_item(input command_type cmd, input logic [31:0] contacts,
                             input logic [4:0] pin, input logic level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_contacts <= contacts;
      req_pin <= pin;
      req_pin_level <= level;
      do @(posedge clock); while (req_stall);
      items_offered++;
   endtask

   task automatic send_tick(input logic [31:0] contacts);
      offer_item(CMD_TICK, contacts, 5'($urandom_range(31)), 1'($urandom_range(1)));
   endtask

   task automatic send_toggle(input logic [4:0] pin, input logic level);
      offer_item(CMD_TOGGLE, $urandom(), pin, level);
   endtask

   // Both registers in one burst of write beats, valid held high between them.
   task automatic set_registers(input logic [7:0] status, input logic [7:0] note);
      csr_valid <= 1'b1;
      csr_index <= CSR_STATUS;
      csr_data <= status;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_BASE_NOTE;
      csr_data <= note;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Wait until every expected beat is out and any scan in flight has finished.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A realistic key stroke: reload, count down, capture, press, release.
   task automatic press_sequence();
      int key;
      int depth;
      logic [31:0] c;
      key = $urandom_range(15);
      depth = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(6);
      c = $urandom();
      c[2*key +: 2] = 2'b00;
      send_tick(c);
      repeat (depth) begin
         c = $urandom();
         c[2*key +: 2] = 2'b11;
         send_tick(c);
      end
      c = $urandom();
      c[2*key +: 2] = 2'b01;
      send_tick(c);
      send_toggle(5'({4'(key), 1'b1}), 1'b0);
      if ($urandom_range(1)) send_tick($urandom());
      send_toggle(5'({4'(key), 1'b1}), 1'b1);
   endtask

   // Mostly key strokes with random content, the rest arbitrary items.
   task automatic random_mix(input int count);
      int start;
      start = items_offered;
      while (items_offered - start < count) begin
         if ($urandom_range(99) < 70)
            press_sequence();
         else
            offer_item(command_type'($urandom_range(1)), $urandom(),
                       5'($urandom_range(31)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_TICK;
      req_contacts <= 32'd0;
      req_pin <= 5'd0;
      req_pin_level <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_STATUS;
      csr_data <= 8'd0;
      send_idle_pct <= 17;
      recv_idle_pct <= 76;
      hold_asks <= 0;
      items_offered = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Lowest status and base note, sender mostly busy, receiver mostly stalled.
      set_registers(8'h80, 8'h00);

      // Directed: press with nothing captured, releases, even pins, then known counts.
      send_toggle(5'd1, 1'b0);
      send_toggle(5'd1, 1'b1);
      send_toggle(5'd0, 1'b0);
      send_toggle(5'd30, 1'b1);
      send_toggle(5'd31, 1'b1);
      send_tick(32'h0000_0000);
      send_tick(32'hffff_ffff);
      send_tick(32'hffff_ffff);
      send_tick(32'h5555_5555);
      send_toggle(5'd31, 1'b0);
      send_toggle(5'd15, 1'b0);
      send_tick(32'haaaa_aaaa);
      send_tick(32'h5555_5555);
      send_toggle(5'd1, 1'b0);
      send_toggle(5'd1, 1'b1);
      send_tick(32'hffff_0000);
      send_tick(32'h5555_ffff);
      send_toggle(5'd17, 1'b0);
      send_toggle(5'd3, 1'b0);
      send_toggle(5'd29, 1'b1);
      random_mix(12);
      settle();

      // Highest status and base note, sender mostly idle.
      send_idle_pct <= 76;
      recv_idle_pct <= 17;
      set_registers(8'hff, 8'd112);
      random_mix(12);
      settle();

      // Status below the usual range, base note past its range so notes wrap.
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      set_registers(8'h3c, 8'hf5);

      // Long hold-off on the result side while toggles keep coming.
      hold_asks <= hold_asks + 1;
      repeat (12) send_toggle(5'({4'($urandom_range(15)), 1'b1}), 1'($urandom_range(1)));

      // Count every counter down for a stretch, capture, and press a few keys.
      send_tick(32'h0000_0000);
      repeat (20) send_tick(32'hffff_ffff);
      send_tick(32'h5555_5555);
      send_toggle(5'd1, 1'b0);
      send_toggle(5'd21, 1'b0);
      send_toggle(5'd31, 1'b0);
      random_mix(8);
      settle();

      // A random legal setting to close out.
      set_registers(8'($urandom_range(255, 128)), 8'($urandom_range(112)));
      random_mix(8);
      settle();

      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
